/* rtl/rgbhls_pkg.sv */
package rgbhls_pkg;

   localparam int QUO_BITS  = 16;
   localparam int HUE_BITS  = 15;
   localparam int FRAC_BITS = 16;
   localparam int RSP_W     = ((HUE_BITS + 2 * FRAC_BITS + 7) / 8) * 8;

   localparam logic [HUE_BITS-1:0]  HUE_SIXTH = HUE_BITS'(3840);
   localparam logic [HUE_BITS-1:0]  HUE_GREEN = HUE_BITS'(7680);
   localparam logic [HUE_BITS-1:0]  HUE_BLUE  = HUE_BITS'(15360);
   localparam logic [HUE_BITS-1:0]  HUE_FULL  = HUE_BITS'(23040);
   localparam logic [FRAC_BITS-1:0] FRAC_ONE  = FRAC_BITS'(65535);

   typedef enum logic [1:0] {
      SEC_RED   = 2'd0,
      SEC_GREEN = 2'd1,
      SEC_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      sector_type sector;
      logic       neg;
      logic       grey;
   } hue_tag_type;

endpackage

/* rtl/rgbhls_div.sv */
module rgbhls_div
   import rgbhls_pkg::*;
#(
   parameter int DW = 9,
   localparam int RW = DW + QUO_BITS
) (
   input  logic                clock,
   input  logic [QUO_BITS-1:0] advance,
   input  logic [RW-1:0]       num,
   input  logic [DW-1:0]       dvs,
   output logic [QUO_BITS-1:0] quo
);

   logic [RW-1:0]       rem_ff [QUO_BITS];
   logic [DW-1:0]       dvs_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
      logic [RW-1:0]       rem_prev;
      logic [DW-1:0]       dvs_prev;
      logic [QUO_BITS-1:0] quo_prev;
      logic [RW-1:0]       trial;
      logic                fits;
      logic [RW-1:0]       rem_in;
      logic [QUO_BITS-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_prev = num;
         assign dvs_prev = dvs;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign dvs_prev = dvs_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      always_comb begin
         trial  = RW'(dvs_prev) << (QUO_BITS - 1 - j);
         fits   = (rem_prev >= trial);
         rem_in = fits ? (rem_prev - trial) : rem_prev;
         quo_in = quo_prev;
         quo_in[QUO_BITS-1-j] = fits;
      end

      always_ff @(posedge clock) begin
         if (advance[j]) begin
            rem_ff[j] <= rem_in;
            dvs_ff[j] <= dvs_prev;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QUO_BITS-1];

endmodule

/* rtl/rgb_to_hls_core.sv */
// RGB to HSL converter, one pixel per word.
// req channel: one RGB pixel per word; red, green and blue sit side by side
// in req_tdata, CHANNEL_BITS each, red lowest, zero padding up to a byte.
// rsp channel: one word per pixel with hue (15 bits, 1/64 degree), lightness
// and saturation (16 bits each, Q0.16) packed from bit 0 up.
// Throughput: one pixel per clock while rsp_tready stays high, with no gaps between pixels.
// From req acceptance to rsp_tvalid a pixel passes the input register, the
// max/min stage, the numerator stage, 16 divider stages and the output register.
// Lightness is a multiply by a constant reciprocal; saturation and hue round
// to nearest in restoring dividers that retire one quotient bit per stage.
// Every stage carries its own valid bit. When rsp_tready is low the words
// pack up behind the output register; bubbles still close up, and
// req_tready drops only once every stage holds a word. Nothing is lost or
// repeated across a stall.
// Reset (synchronous, active high) empties the pipeline; no word in flight
// survives it. There is no state from one pixel to the next.
module rgb_to_hls_core
   import rgbhls_pkg::*;
#(
   parameter int CHANNEL_BITS = 8,
   localparam int REQ_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // red, green, blue
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // hue, lightness, saturation
);

   localparam int CB     = CHANNEL_BITS;
   localparam int SW     = CB + 1;
   localparam int DW     = CB + 1;
   localparam int RW     = DW + QUO_BITS;
   localparam int DIV0   = 3;
   localparam int STAGES = DIV0 + QUO_BITS + 1;
   localparam logic [CB-1:0] CMAX = '1;

   localparam longint unsigned LMAX = (64'd1 << CB) - 64'd1;
   localparam longint unsigned LDEN = 2 * LMAX;
   localparam int LK  = $clog2((LDEN + 1) * LDEN);
   localparam int LPW = LK + FRAC_BITS;
   localparam longint unsigned LMUL = ((64'(FRAC_ONE) << LK) + LDEN - 1) / LDEN;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

   // input register
   logic [CB-1:0] red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         red_ff   <= req_tdata[CB-1:0];
         green_ff <= req_tdata[2*CB-1:CB];
         blue_ff  <= req_tdata[3*CB-1:2*CB];
      end
   end

   // max, min, sector
   logic [CB-1:0] hi, lo, opa, opb;
   sector_type    sector_in;
   logic [SW-1:0] sum_ff;
   logic [CB-1:0] delta_ff, diff_ff;
   logic          neg_ff;
   sector_type    sector_ff;

   always_comb begin
      hi = red_ff;
      lo = red_ff;
      if (green_ff > hi) hi = green_ff;
      if (blue_ff > hi) hi = blue_ff;
      if (green_ff < lo) lo = green_ff;
      if (blue_ff < lo) lo = blue_ff;
      if (hi == red_ff) begin
         sector_in = SEC_RED;
         opa = green_ff;
         opb = blue_ff;
      end else if (hi == green_ff) begin
         sector_in = SEC_GREEN;
         opa = blue_ff;
         opb = red_ff;
      end else begin
         sector_in = SEC_BLUE;
         opa = red_ff;
         opb = green_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sum_ff    <= SW'(hi) + SW'(lo);
         delta_ff  <= hi - lo;
         diff_ff   <= (opa >= opb) ? (opa - opb) : (opb - opa);
         neg_ff    <= (opa < opb);
         sector_ff <= sector_in;
      end
   end

   // numerators, doubled divisors and lightness
   logic [CB-1:0]        den;
   logic [LPW-1:0]       light_prod;
   logic [FRAC_BITS-1:0] light2_ff;
   logic [RW-1:0]        sat_num_ff, hue_num_ff;
   logic [DW-1:0]        sat_dvs_ff, hue_dvs_ff;
   hue_tag_type          tag2_ff;

   always_comb begin
      if (sum_ff <= SW'(CMAX)) begin
         den = sum_ff[CB-1:0];
      end else begin
         den = CB'({CMAX, 1'b0} - sum_ff);
      end
      light_prod = LPW'(sum_ff) * LPW'(LMUL) + (LPW'(1) << (LK - 1));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         light2_ff      <= light_prod[LK +: FRAC_BITS];
         sat_num_ff     <= ((RW'(delta_ff) * RW'(FRAC_ONE)) << 1) + RW'(den);
         hue_num_ff     <= ((RW'(diff_ff) * RW'(HUE_SIXTH)) << 1) + RW'(delta_ff);
         sat_dvs_ff     <= {den, 1'b0};
         hue_dvs_ff     <= {delta_ff, 1'b0};
         tag2_ff.sector <= sector_ff;
         tag2_ff.neg    <= neg_ff;
         tag2_ff.grey   <= (delta_ff == '0);
      end
   end

   // dividers
   logic [QUO_BITS-1:0]  sat_quo, hue_quo;
   hue_tag_type          tag_ff [QUO_BITS];
   logic [FRAC_BITS-1:0] light_ff [QUO_BITS];

   rgbhls_div #(.DW(DW)) u_sat_div (
      .clock   (clock),
      .advance (en[DIV0 +: QUO_BITS]),
      .num     (sat_num_ff),
      .dvs     (sat_dvs_ff),
      .quo     (sat_quo)
   );

   rgbhls_div #(.DW(DW)) u_hue_div (
      .clock   (clock),
      .advance (en[DIV0 +: QUO_BITS]),
      .num     (hue_num_ff),
      .dvs     (hue_dvs_ff),
      .quo     (hue_quo)
   );

   always_ff @(posedge clock) begin
      if (en[DIV0]) begin
         tag_ff[0]   <= tag2_ff;
         light_ff[0] <= light2_ff;
      end
      for (int j = 1; j < QUO_BITS; j++) begin
         if (en[DIV0+j]) begin
            tag_ff[j]   <= tag_ff[j-1];
            light_ff[j] <= light_ff[j-1];
         end
      end
   end

   // hue assembly and output register
   hue_tag_type          tag_q;
   logic [HUE_BITS-1:0]  mag, center, hue_in;
   logic [FRAC_BITS-1:0] sat_in;
   logic [RSP_W-1:0]     rsp_ff;

   always_comb begin
      tag_q = tag_ff[QUO_BITS-1];
      mag   = hue_quo[HUE_BITS-1:0];
      case (tag_q.sector)
         SEC_GREEN: center = HUE_GREEN;
         SEC_BLUE:  center = HUE_BLUE;
         default:   center = '0;
      endcase
      if (tag_q.grey) begin
         hue_in = '0;
      end else if (!tag_q.neg) begin
         hue_in = center + mag;
      end else if (tag_q.sector == SEC_RED) begin
         hue_in = (mag == '0) ? '0 : (HUE_FULL - mag);
      end else begin
         hue_in = center - mag;
      end
      sat_in = tag_q.grey ? '0 : sat_quo[FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[STAGES-1]) begin
         rsp_ff <= RSP_W'({sat_in, light_ff[QUO_BITS-1], hue_in});
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule
